[rtl/multi_sensor_range_smoother_assert.svh]
// ----------------------------------------------------------------------------
// assertion macros for the range smoother
// implication forms used by the concurrent checks of the design
// ----------------------------------------------------------------------------
`ifndef MULTI_SENSOR_RANGE_SMOOTHER_ASSERT_SVH
`define MULTI_SENSOR_RANGE_SMOOTHER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define MSRS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("range smoother check failed");

// next-cycle implication, disabled while in reset
`define MSRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("range smoother check failed");

`endif

[rtl/msrs_pkg.sv]
// ----------------------------------------------------------------------------
// msrs_pkg
// shared types and constants of the range smoother
// ----------------------------------------------------------------------------
`default_nettype none

package msrs_pkg;

    localparam int SENSOR_COUNT_DEF = 3;
    localparam int FRONT_INDEX_DEF  = 0;

    localparam int CHANNEL_W = 2;
    localparam int TIME_W    = 32;
    localparam int ALPHA_W   = 17;
    localparam int LIMIT_W   = 16;
    localparam int SMOOTH_W  = 24;
    localparam int DIST_W    = 9;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 17;

    localparam logic [ALPHA_W-1:0]  ONE_Q16    = 17'h10000;
    localparam logic [SMOOTH_W-1:0] HALF_Q16   = 24'h008000;
    localparam logic [2:0]          READY_MASK = 3'h7;
    localparam logic [2:0]          READY_CODE = 3'h4;
    localparam logic [DIST_W-1:0]   NO_READING = 9'h1ff;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRONT_ALPHA   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIDE_ALPHA    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STALE_LIMIT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RETRY_BACKOFF = 2'd3;

    localparam logic [ALPHA_W-1:0] FRONT_ALPHA_RST   = 17'd16384;
    localparam logic [ALPHA_W-1:0] SIDE_ALPHA_RST    = 17'd16384;
    localparam logic [LIMIT_W-1:0] STALE_LIMIT_RST   = 16'd100;
    localparam logic [LIMIT_W-1:0] RETRY_BACKOFF_RST = 16'd500;

    // one per-sensor state entry as kept in the state memory
    typedef struct packed {
        logic                online;
        logic                has_sample;
        logic [SMOOTH_W-1:0] smoothed;
        logic [TIME_W-1:0]   last_time;
        logic [TIME_W-1:0]   retry_time;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

[rtl/msrs_ram.sv]
// ----------------------------------------------------------------------------
// msrs_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module msrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic                                  re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/multi_sensor_range_smoother.sv]
// ----------------------------------------------------------------------------
// multi_sensor_range_smoother
// flow: an accepted word is registered in stage 1, and its result word is then
//   registered in the output register, which drives the outputs
// throughput: one word per cycle while out_ready does not stall the output; the
//   state read-modify-write loop, with the last write forwarded, sets that figure
// reset: all sensors offline with cleared state through per-entry valid bits;
//   registers return to their defaults, no clearing pass is needed
// ----------------------------------------------------------------------------
`default_nettype none

`include "multi_sensor_range_smoother_assert.svh"

module multi_sensor_range_smoother
    import msrs_pkg::*;
#(
    parameter int SENSOR_COUNT = SENSOR_COUNT_DEF,
    parameter int FRONT_INDEX  = FRONT_INDEX_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // configuration write port
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [CFG_DAT_W-1:0]     cfg_wdata,
    // poll words in
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [CHANNEL_W-1:0]     channel,
    input  wire logic [TIME_W-1:0]        now_ms,
    input  wire logic [7:0]               irq_status,
    input  wire logic [7:0]               range_mm,
    input  wire logic                     bus_timeout,
    input  wire logic                     bringup_ok,
    // result words out
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [CHANNEL_W-1:0]          sensor_id,
    output logic signed [DIST_W-1:0]      distance_mm,
    output logic                          reading_valid,
    output logic                          sensor_online,
    output logic                          bringup_tried,
    output logic                          clear_irq,
    output logic                          went_stale
);

    // state memory address width
    localparam int AW = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
    // channel widened so it can carry any address
    localparam int XW = (AW > CHANNEL_W) ? AW : CHANNEL_W;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [ALPHA_W-1:0] front_alpha_reg;
    logic [ALPHA_W-1:0] side_alpha_reg;
    logic [LIMIT_W-1:0] stale_limit_reg;
    logic [LIMIT_W-1:0] retry_backoff_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_alpha_reg   <= FRONT_ALPHA_RST;
            side_alpha_reg    <= SIDE_ALPHA_RST;
            stale_limit_reg   <= STALE_LIMIT_RST;
            retry_backoff_reg <= RETRY_BACKOFF_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRONT_ALPHA:   front_alpha_reg   <= cfg_wdata;
                REG_SIDE_ALPHA:    side_alpha_reg    <= cfg_wdata;
                REG_STALE_LIMIT:   stale_limit_reg   <= cfg_wdata[LIMIT_W-1:0];
                REG_RETRY_BACKOFF: retry_backoff_reg <= cfg_wdata[LIMIT_W-1:0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // handshake and stage control
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s1_valid_next;
    logic out_valid_reg;
    logic s1_adv;
    logic in_accept;

    // stage 1 hands its word to the output register when that is free
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || s1_adv;
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // accept: issue the state read and capture the poll
    // ------------------------------------------------------------------
    logic [XW-1:0]        in_ch_x;
    logic [AW-1:0]        in_addr;
    logic                 in_in_range;

    assign in_ch_x     = XW'(channel);
    assign in_addr     = in_ch_x[AW-1:0];
    assign in_in_range = (32'(channel) < SENSOR_COUNT);

    logic [CHANNEL_W-1:0] s1_ch_reg;
    logic [AW-1:0]        s1_addr_reg;
    logic                 s1_in_range_reg;
    logic                 s1_front_reg;
    logic [TIME_W-1:0]    s1_now_reg;
    logic [7:0]           s1_status_reg;
    logic [7:0]           s1_range_reg;
    logic                 s1_timeout_reg;
    logic                 s1_ok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_ch_reg       <= channel;
            s1_addr_reg     <= in_addr;
            s1_in_range_reg <= in_in_range;
            s1_front_reg    <= (32'(channel) == FRONT_INDEX);
            s1_now_reg      <= now_ms;
            s1_status_reg   <= irq_status;
            s1_range_reg    <= range_mm;
            s1_timeout_reg  <= bus_timeout;
            s1_ok_reg       <= bringup_ok;
        end
    end

    // ------------------------------------------------------------------
    // state memory, entry valid bits and write forwarding
    // ------------------------------------------------------------------
    logic                    mem_we;
    logic [ENTRY_W-1:0]      mem_rdata;
    entry_t                  e_new;
    logic [SENSOR_COUNT-1:0] vld_reg;
    logic                    fwd_valid_reg;
    logic [AW-1:0]           fwd_addr_reg;
    entry_t                  fwd_data_reg;

    // only in-range sensors write the memory
    assign mem_we = s1_adv && s1_in_range_reg;

    msrs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SENSOR_COUNT)
    ) u_state_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (s1_addr_reg),
        .wdata (e_new),
        .re    (in_accept),
        .raddr (in_addr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else if (mem_we)
        begin
            vld_reg[s1_addr_reg] <= 1'b1;
            fwd_valid_reg        <= 1'b1;
        end
    end

    // the last write may land on the same edge as the read of the next word
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_data_reg <= e_new;
        end
    end

    entry_t e_cur;

    always_comb
    begin
        priority if (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg))
        begin
            e_cur = fwd_data_reg;
        end
        else if (vld_reg[s1_addr_reg])
        begin
            e_cur = entry_t'(mem_rdata);
        end
        else
        begin
            // never-written entry reads as its reset value
            e_cur = '0;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: update of one sensor entry
    // ------------------------------------------------------------------
    logic [TIME_W-1:0]       retry_diff;
    logic [TIME_W-1:0]       stale_diff;
    logic                    retry_due;
    logic                    sample_ready;
    logic                    is_stale;
    logic [ALPHA_W-1:0]      alpha_sel;
    logic [ALPHA_W-1:0]      alpha;
    logic signed [SMOOTH_W:0]   delta;
    logic signed [ALPHA_W:0]    alpha_s;
    logic signed [SMOOTH_W+ALPHA_W+1:0] prod;
    logic signed [SMOOTH_W+ALPHA_W+1:0] prod_rnd;
    logic signed [SMOOTH_W+ALPHA_W+1:0] step;
    logic [SMOOTH_W:0]       blend_sum;
    logic [SMOOTH_W-1:0]     blended;
    logic                    tried;
    logic                    took;
    logic                    stale_hit;
    logic [SMOOTH_W-1:0]     dist_sum;
    logic [DIST_W-1:0]       dist_val;

    // wrapped time differences; retry is due when the difference is not negative
    assign retry_diff   = s1_now_reg - e_cur.retry_time;
    assign stale_diff   = s1_now_reg - e_cur.last_time;
    assign retry_due    = !retry_diff[TIME_W-1];
    assign is_stale     = (stale_diff > TIME_W'(stale_limit_reg));
    assign sample_ready = !s1_timeout_reg && ((s1_status_reg[2:0] & READY_MASK) == READY_CODE);

    // alpha above one counts as one
    assign alpha_sel = s1_front_reg ? front_alpha_reg : side_alpha_reg;
    assign alpha     = (alpha_sel > ONE_Q16) ? ONE_Q16 : alpha_sel;

    // s' = s + round((r<<16 - s) * a / 2^16), one signed multiply
    assign delta     = $signed({1'b0, s1_range_reg, 16'h0000}) - $signed({1'b0, e_cur.smoothed});
    assign alpha_s   = $signed({1'b0, alpha});
    assign prod      = delta * alpha_s;
    assign prod_rnd  = prod + $signed((SMOOTH_W+ALPHA_W+2)'(HALF_Q16));
    assign step      = prod_rnd >>> 16;
    assign blend_sum = {1'b0, e_cur.smoothed} + step[SMOOTH_W:0];
    assign blended   = blend_sum[SMOOTH_W-1:0];

    always_comb
    begin
        e_new     = e_cur;
        tried     = 1'b0;
        took      = 1'b0;
        stale_hit = 1'b0;
        priority if (!e_cur.online)
        begin
            if (retry_due)
            begin
                tried            = 1'b1;
                e_new.has_sample = 1'b0;
                e_new.smoothed   = '0;
                if (s1_ok_reg)
                begin
                    e_new.online    = 1'b1;
                    e_new.last_time = s1_now_reg;
                end
                else
                begin
                    e_new.retry_time = s1_now_reg + TIME_W'(retry_backoff_reg);
                end
            end
        end
        else if (sample_ready)
        begin
            took = 1'b1;
            // first sample after bring-up is taken as is
            e_new.smoothed   = e_cur.has_sample ? blended : {s1_range_reg, 16'h0000};
            e_new.has_sample = 1'b1;
            e_new.last_time  = s1_now_reg;
        end
        else if (is_stale)
        begin
            stale_hit        = 1'b1;
            e_new.online     = 1'b0;
            e_new.has_sample = 1'b0;
            e_new.smoothed   = '0;
            e_new.retry_time = s1_now_reg;
        end
    end

    // rounded distance; never above 255 so the top bit stays clear
    assign dist_sum = e_new.smoothed + HALF_Q16;
    assign dist_val = e_new.has_sample ? {1'b0, dist_sum[SMOOTH_W-1:16]} : NO_READING;

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    logic [CHANNEL_W-1:0] o_id_reg;
    logic [DIST_W-1:0]    o_dist_reg;
    logic                 o_has_reg;
    logic                 o_online_reg;
    logic                 o_tried_reg;
    logic                 o_took_reg;
    logic                 o_stale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            o_id_reg <= s1_ch_reg;
            // out-of-range channel: no reading, all flags low
            if (s1_in_range_reg)
            begin
                o_dist_reg   <= dist_val;
                o_has_reg    <= e_new.has_sample;
                o_online_reg <= e_new.online;
                o_tried_reg  <= tried;
                o_took_reg   <= took;
                o_stale_reg  <= stale_hit;
            end
            else
            begin
                o_dist_reg   <= NO_READING;
                o_has_reg    <= 1'b0;
                o_online_reg <= 1'b0;
                o_tried_reg  <= 1'b0;
                o_took_reg   <= 1'b0;
                o_stale_reg  <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign sensor_id     = o_id_reg;
    assign distance_mm   = $signed(o_dist_reg);
    assign reading_valid = o_has_reg;
    assign sensor_online = o_online_reg;
    assign bringup_tried = o_tried_reg;
    assign clear_irq     = o_took_reg;
    assign went_stale    = o_stale_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // at most one of the three actions per word
    `MSRS_ASSERT_NOW(a_one_action, clk, rst_n, out_valid_reg,
        $countones({o_tried_reg, o_took_reg, o_stale_reg}) <= 1)
    // a taken sample leaves the sensor online with a reading
    `MSRS_ASSERT_NOW(a_took_online, clk, rst_n, out_valid_reg && o_took_reg,
        o_online_reg && o_has_reg)
    // going stale clears online and reading
    `MSRS_ASSERT_NOW(a_stale_offline, clk, rst_n, out_valid_reg && o_stale_reg,
        !o_online_reg && !o_has_reg)
    // the no-reading code appears exactly when there is no reading
    `MSRS_ASSERT_NOW(a_dist_code, clk, rst_n, out_valid_reg,
        o_has_reg == (o_dist_reg != NO_READING))
    // a stalled stage 1 word keeps its channel and never writes the memory
    `MSRS_ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_valid_reg && !s1_adv,
        s1_valid_reg && $stable(s1_ch_reg) && $stable(vld_reg))

endmodule

`default_nettype wire
